@@ hw/rtl/ndpc_pkg.sv @@
// ndpc_pkg: shared types, constants and helper functions for the ipv6 ndp header classifier
// no dependencies; used by every module under hw/rtl

package ndpc_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 2048;
	localparam int FIFO_DEPTH          = 2;

	localparam logic [15:0] ETYPE_IP6      = 16'h86DD;
	localparam logic [7:0]  NH_HOP_BY_HOP  = 8'd0;
	localparam logic [7:0]  NH_ROUTING     = 8'd43;
	localparam logic [7:0]  NH_FRAGMENT    = 8'd44;
	localparam logic [7:0]  NH_ICMPV6      = 8'd58;
	localparam logic [7:0]  NH_DEST_OPTS   = 8'd60;
	localparam logic [7:0]  HOP_LIMIT_OK   = 8'd255;
	localparam logic [7:0]  NDP_TYPE_LO    = 8'd133;
	localparam logic [7:0]  NDP_TYPE_HI    = 8'd137;
	localparam logic [7:0]  ADDR_MCAST     = 8'hFF;
	localparam logic [10:0] OFFSET_MAX     = 11'd2047;

	// byte positions in the frame
	localparam int POS_MAC_SRC_FIRST = 6;
	localparam int POS_MAC_SRC_LAST  = 11;
	localparam int POS_MAC_SRC_END   = 12;
	localparam int POS_ETYPE_HI      = 12;
	localparam int POS_ETYPE_LO      = 13;
	localparam int POS_ETYPE_END     = 14;
	localparam int POS_NEXT_HDR      = 20;
	localparam int POS_HOP_LIMIT     = 21;
	localparam int POS_IP_SRC_FIRST  = 22;
	localparam int POS_IP_SRC_LAST   = 37;
	localparam int POS_CHAIN_START   = 54;

	typedef enum logic [3:0] {
		PH_WALK  = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_FOUND = 4'b0100,
		PH_STOP  = 4'b1000
	} phase_t;

	// raw verdict from the front, masked by the back
	typedef struct packed {
		logic        ipv6;
		logic        src_zero;
		logic        found;
		logic [10:0] offset;
		logic [7:0]  icmp_type;
		logic        mac_bad;
		logic        src_mcast;
		logic        hop_ok;
	} verdict_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	// ipv6 all-nodes multicast mac 33:33:00:00:00:01
	function automatic logic [7:0] mac_multi_byte(input logic [2:0] pos);
		logic [7:0] r;
		unique case (pos)
			3'd0:    r = 8'h33;
			3'd1:    r = 8'h33;
			3'd5:    r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic is_ext_header(input logic [7:0] nh);
		logic r;
		unique case (nh) inside
			NH_HOP_BY_HOP, NH_ROUTING, NH_FRAGMENT, NH_DEST_OPTS: r = 1'b1;
			default:                                            r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/ndpc_front.sv @@
// ndpc_front: per-byte frame parser, walks the extension header chain
// depends on ndpc_pkg; pushes one raw verdict per frame into the queue

module ndpc_front #(
	parameter int MAX_FRAME_BYTES = ndpc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               push,
	output ndpc_pkg::verdict_t verdict
);

	localparam int IDXW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int SW   = $clog2(MAX_FRAME_BYTES);
	localparam int OFW  = (IDXW > 11) ? IDXW : 11;
	localparam int NXW  = OFW + 1;

	logic [IDXW-1:0]        idx_q, idx_d;
	logic [15:0]            etype_q, etype_d;
	logic [2:0]             mac_q, mac_d;
	logic                   src_zero_q, src_zero_d;
	logic [7:0]             src_first_q, src_first_d;
	logic [7:0]             hop_q, hop_d;
	logic [7:0]             nh_q, nh_d;
	logic [SW-1:0]          start_q, start_d;
	ndpc_pkg::phase_t       phase_q, phase_d;
	logic [10:0]            off_q, off_d;
	logic [7:0]             type_q, type_d;

	logic                   in_range;
	logic [IDXW-1:0]        mac_off;
	logic [OFW-1:0]         idx_wide;
	logic [NXW-1:0]         hdr_len;
	logic [NXW-1:0]         next_start;
	logic [2:0]             mac_eff;

	assign in_range   = idx_q < IDXW'(MAX_FRAME_BYTES);
	assign mac_off    = idx_q - IDXW'(ndpc_pkg::POS_MAC_SRC_FIRST);
	assign idx_wide   = OFW'(idx_q);
	assign hdr_len    = (NXW'(data_byte) + NXW'(1)) << 3;
	assign next_start = NXW'(start_q) + hdr_len;

	always_comb begin
		idx_d       = idx_q;
		etype_d     = etype_q;
		mac_d       = mac_q;
		src_zero_d  = src_zero_q;
		src_first_d = src_first_q;
		hop_d       = hop_q;
		nh_d        = nh_q;
		start_d     = start_q;
		phase_d     = phase_q;
		off_d       = off_q;
		type_d      = type_q;
		if (in_range) begin
			idx_d = idx_q + IDXW'(1);
			if (idx_q >= IDXW'(ndpc_pkg::POS_MAC_SRC_FIRST) &&
			    idx_q <= IDXW'(ndpc_pkg::POS_MAC_SRC_LAST)) begin
				if (data_byte != 8'h00) mac_d[0] = 1'b0;
				if (data_byte != 8'hFF) mac_d[1] = 1'b0;
				if (data_byte != ndpc_pkg::mac_multi_byte(mac_off[2:0])) mac_d[2] = 1'b0;
			end
			if (idx_q == IDXW'(ndpc_pkg::POS_ETYPE_HI) ||
			    idx_q == IDXW'(ndpc_pkg::POS_ETYPE_LO))
				etype_d = {etype_q[7:0], data_byte};
			if (idx_q == IDXW'(ndpc_pkg::POS_NEXT_HDR)) nh_d = data_byte;
			if (idx_q == IDXW'(ndpc_pkg::POS_HOP_LIMIT)) hop_d = data_byte;
			if (idx_q == IDXW'(ndpc_pkg::POS_IP_SRC_FIRST)) src_first_d = data_byte;
			if (idx_q >= IDXW'(ndpc_pkg::POS_IP_SRC_FIRST) &&
			    idx_q <= IDXW'(ndpc_pkg::POS_IP_SRC_LAST) && data_byte != 8'h00)
				src_zero_d = 1'b0;

			unique case (phase_q) inside
				ndpc_pkg::PH_WALK: begin
					if (idx_q == IDXW'(start_q)) begin
						if (ndpc_pkg::is_ext_header(nh_q)) begin
							nh_d    = data_byte;
							phase_d = ndpc_pkg::PH_LEN;
						end else if (nh_q == ndpc_pkg::NH_ICMPV6) begin
							off_d   = (idx_wide > OFW'(ndpc_pkg::OFFSET_MAX)) ?
							          ndpc_pkg::OFFSET_MAX : idx_wide[10:0];
							type_d  = data_byte;
							phase_d = ndpc_pkg::PH_FOUND;
						end else begin
							phase_d = ndpc_pkg::PH_STOP;
						end
					end
				end
				ndpc_pkg::PH_LEN: begin
					if (idx_q == IDXW'(start_q) + IDXW'(1)) begin
						if (next_start >= NXW'(MAX_FRAME_BYTES)) begin
							phase_d = ndpc_pkg::PH_STOP;
						end else begin
							start_d = next_start[SW-1:0];
							phase_d = ndpc_pkg::PH_WALK;
						end
					end
				end
				ndpc_pkg::PH_FOUND, ndpc_pkg::PH_STOP: begin
				end
				default: begin
					phase_d = ndpc_pkg::PH_STOP;
				end
			endcase
		end
	end

	// mac bytes never received count as zero
	assign mac_eff = (idx_d < IDXW'(ndpc_pkg::POS_MAC_SRC_END)) ? {2'b00, mac_d[0]} : mac_d;

	always_comb begin
		verdict.ipv6      = (idx_d >= IDXW'(ndpc_pkg::POS_ETYPE_END)) &&
		                    (etype_d == ndpc_pkg::ETYPE_IP6);
		verdict.src_zero  = src_zero_d;
		verdict.found     = (phase_d == ndpc_pkg::PH_FOUND);
		verdict.offset    = off_d;
		verdict.icmp_type = type_d;
		verdict.mac_bad   = |mac_eff;
		verdict.src_mcast = (src_first_d == ndpc_pkg::ADDR_MCAST);
		verdict.hop_ok    = (hop_d == ndpc_pkg::HOP_LIMIT_OK);
	end

	assign push = take & last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			etype_q     <= '0;
			mac_q       <= 3'b111;
			src_zero_q  <= 1'b1;
			src_first_q <= '0;
			hop_q       <= '0;
			nh_q        <= '0;
			start_q     <= SW'(ndpc_pkg::POS_CHAIN_START);
			phase_q     <= ndpc_pkg::PH_WALK;
			off_q       <= '0;
			type_q      <= '0;
		end else if (take) begin
			if (last_byte) begin
				idx_q       <= '0;
				etype_q     <= '0;
				mac_q       <= 3'b111;
				src_zero_q  <= 1'b1;
				src_first_q <= '0;
				hop_q       <= '0;
				nh_q        <= '0;
				start_q     <= SW'(ndpc_pkg::POS_CHAIN_START);
				phase_q     <= ndpc_pkg::PH_WALK;
				off_q       <= '0;
				type_q      <= '0;
			end else begin
				idx_q       <= idx_d;
				etype_q     <= etype_d;
				mac_q       <= mac_d;
				src_zero_q  <= src_zero_d;
				src_first_q <= src_first_d;
				hop_q       <= hop_d;
				nh_q        <= nh_d;
				start_q     <= start_d;
				phase_q     <= phase_d;
				off_q       <= off_d;
				type_q      <= type_d;
			end
		end
	end

endmodule

@@ hw/rtl/ndpc_fifo.sv @@
// ndpc_fifo: short verdict queue between the parser and the output stage
// depends on ndpc_pkg

module ndpc_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ndpc_pkg::verdict_t     wr_data,
	input  logic                   pop,
	output ndpc_pkg::verdict_t     rd_data,
	output ndpc_pkg::fifo_status_t status
);

	localparam int DEPTH = ndpc_pkg::FIFO_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	ndpc_pkg::verdict_t mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty) else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!status.full || pop)) else $error("push into full queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count not incremented");

endmodule

@@ hw/rtl/ndpc_back.sv @@
// ndpc_back: output stage, masks raw verdicts into result fields and holds them
// depends on ndpc_pkg; drained from ndpc_fifo

module ndpc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ndpc_pkg::verdict_t     rd_data,
	input  ndpc_pkg::fifo_status_t status,
	output logic                   pop,
	output logic                   verdict_valid,
	input  logic                   verdict_ready,
	output logic                   is_ipv6,
	output logic                   src_specified,
	output logic                   is_icmpv6,
	output logic [10:0]            icmp_offset,
	output logic [7:0]             icmp_type,
	output logic                   is_ndp,
	output logic                   eth_src_broadcast,
	output logic                   ip_src_multicast,
	output logic                   hop_limit_bad
);

	logic        valid_q;
	logic        found;
	logic        ipv6_q, spec_q, icmp_q, ndp_q, mac_q, mcast_q, hop_q;
	logic [10:0] off_q;
	logic [7:0]  type_q;

	assign pop   = !status.empty && (!valid_q || verdict_ready);
	assign found = rd_data.ipv6 && rd_data.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (pop) valid_q <= 1'b1;
		else if (verdict_ready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ipv6_q  <= rd_data.ipv6;
			spec_q  <= rd_data.ipv6 && !rd_data.src_zero;
			icmp_q  <= found;
			off_q   <= found ? rd_data.offset : '0;
			type_q  <= found ? rd_data.icmp_type : '0;
			ndp_q   <= found && rd_data.icmp_type >= ndpc_pkg::NDP_TYPE_LO &&
			           rd_data.icmp_type <= ndpc_pkg::NDP_TYPE_HI;
			mac_q   <= rd_data.mac_bad;
			mcast_q <= rd_data.ipv6 && rd_data.src_mcast;
			hop_q   <= rd_data.ipv6 && !rd_data.hop_ok;
		end
	end

	assign verdict_valid     = valid_q;
	assign is_ipv6           = ipv6_q;
	assign src_specified     = spec_q;
	assign is_icmpv6         = icmp_q;
	assign icmp_offset       = off_q;
	assign icmp_type         = type_q;
	assign is_ndp            = ndp_q;
	assign eth_src_broadcast = mac_q;
	assign ip_src_multicast  = mcast_q;
	assign hop_limit_bad     = hop_q;

endmodule

@@ hw/rtl/ipv6_ndp_header_classifier.sv @@
// ipv6_ndp_header_classifier: top level, byte parser, verdict queue and output stage
// depends on ndpc_pkg, ndpc_front, ndpc_fifo, ndpc_back
// throughput: one frame byte per cycle, back-to-back frames of any length, while verdicts drain
// verdict path: the last byte's verdict is written into the queue, then registered at the output once it is free
// input stalls only when the two-entry queue is full behind a verdict held at the output
// reset: asynchronous, clears parser state, queue pointers and the output valid

module ipv6_ndp_header_classifier #(
	parameter int MAX_FRAME_BYTES = ndpc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        verdict_valid,
	input  logic        verdict_ready,
	output logic        is_ipv6,
	output logic        src_specified,
	output logic        is_icmpv6,
	output logic [10:0] icmp_offset,
	output logic [7:0]  icmp_type,
	output logic        is_ndp,
	output logic        eth_src_broadcast,
	output logic        ip_src_multicast,
	output logic        hop_limit_bad
);

	logic                   take;
	logic                   push;
	logic                   pop;
	ndpc_pkg::verdict_t     wr_data;
	ndpc_pkg::verdict_t     rd_data;
	ndpc_pkg::fifo_status_t status;

	assign data_ready = !status.full;
	assign take       = data_valid && data_ready;

	ndpc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.push     (push),
		.verdict  (wr_data)
	);

	ndpc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(wr_data),
		.pop    (pop),
		.rd_data(rd_data),
		.status (status)
	);

	ndpc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.rd_data          (rd_data),
		.status           (status),
		.pop              (pop),
		.verdict_valid    (verdict_valid),
		.verdict_ready    (verdict_ready),
		.is_ipv6          (is_ipv6),
		.src_specified    (src_specified),
		.is_icmpv6        (is_icmpv6),
		.icmp_offset      (icmp_offset),
		.icmp_type        (icmp_type),
		.is_ndp           (is_ndp),
		.eth_src_broadcast(eth_src_broadcast),
		.ip_src_multicast (ip_src_multicast),
		.hop_limit_bad    (hop_limit_bad)
	);

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for ipv6_ndp_header_classifier, frames fed one word per handshake
// depends on ndpc_pkg and the classifier rtl; predicts each verdict from the accepted words
`timescale 1ns / 100ps

module tb;

	localparam int FRAME_CAP   = ndpc_pkg::MAX_FRAME_BYTES_DEF;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_WORDS = 120;
	localparam int MIN_FRAMES  = 2;
	localparam int TAIL_CYCLES = 10;

	localparam logic [7:0] ALL_NODES_MAC [6] = '{8'h33, 8'h33, 8'h00, 8'h00, 8'h00, 8'h01};
	localparam logic [7:0] CHAIN_TYPES [4] = '{ndpc_pkg::NH_HOP_BY_HOP, ndpc_pkg::NH_ROUTING,
		ndpc_pkg::NH_FRAGMENT, ndpc_pkg::NH_DEST_OPTS};

	typedef enum {MAC_RAND, MAC_ZERO, MAC_ONES, MAC_MCAST, MAC_NEAR} mac_kind_t;
	typedef enum {SRC_RAND, SRC_ZERO, SRC_MCAST, SRC_ONE_SET} src_kind_t;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} frame_word_t;

	typedef struct packed {
		logic        ipv6;
		logic        src_spec;
		logic        icmp;
		logic [10:0] off;
		logic [7:0]  typ;
		logic        ndp;
		logic        mac_bcast;
		logic        src_mcast;
		logic        hop_bad;
	} ndp_verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        verdict_valid;
	logic        verdict_ready = 1'b0;
	logic        is_ipv6;
	logic        src_specified;
	logic        is_icmpv6;
	logic [10:0] icmp_offset;
	logic [7:0]  icmp_type;
	logic        is_ndp;
	logic        eth_src_broadcast;
	logic        ip_src_multicast;
	logic        hop_limit_bad;

	frame_word_t  pending_words[$];
	ndp_verdict_t expected_verdicts[$];
	logic [7:0]   frame_buf[$];
	int           icmp_slot;
	int           n_words;
	int           snd_idle_pct;
	int           rcv_idle_pct;
	int           err_cnt;
	int           n_verdicts;
	int           stall_cnt;
	int           hold_left;
	logic         hold_done;

	// predictor state for the frame in flight
	int               fr_idx;
	logic [15:0]      etype_acc;
	logic [2:0]       mac_cand;
	logic             src_all_zero;
	logic [7:0]       src_lead;
	logic [7:0]       hop_seen;
	logic [7:0]       nh_cur;
	int               hdr_start;
	ndpc_pkg::phase_t walk;
	logic [10:0]      icmp_pos;
	logic [7:0]       icmp_ty;

	ipv6_ndp_header_classifier DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.data_valid        (data_valid),
		.data_ready        (data_ready),
		.data_byte         (data_byte),
		.last_byte         (last_byte),
		.verdict_valid     (verdict_valid),
		.verdict_ready     (verdict_ready),
		.is_ipv6           (is_ipv6),
		.src_specified     (src_specified),
		.is_icmpv6         (is_icmpv6),
		.icmp_offset       (icmp_offset),
		.icmp_type         (icmp_type),
		.is_ndp            (is_ndp),
		.eth_src_broadcast (eth_src_broadcast),
		.ip_src_multicast  (ip_src_multicast),
		.hop_limit_bad     (hop_limit_bad)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic chained_header(input logic [7:0] nh);
		case (nh) inside
			ndpc_pkg::NH_HOP_BY_HOP, ndpc_pkg::NH_ROUTING, ndpc_pkg::NH_FRAGMENT,
			ndpc_pkg::NH_DEST_OPTS: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic clear_frame_state();
		fr_idx = 0;
		etype_acc = 16'h0000;
		mac_cand = 3'b111;
		src_all_zero = 1'b1;
		src_lead = 8'h00;
		hop_seen = 8'h00;
		nh_cur = 8'h00;
		hdr_start = ndpc_pkg::POS_CHAIN_START;
		walk = ndpc_pkg::PH_WALK;
		icmp_pos = 11'd0;
		icmp_ty = 8'h00;
	endtask

	task automatic classify_byte(input logic [7:0] b, input logic fin);
		ndp_verdict_t v;
		logic [2:0]   mac;
		logic         ipv6;
		logic         found;
		int           nxt;
		if (fr_idx < FRAME_CAP) begin
			if (fr_idx >= ndpc_pkg::POS_MAC_SRC_FIRST && fr_idx <= ndpc_pkg::POS_MAC_SRC_LAST)
			begin
				if (b != 8'h00) mac_cand[0] = 1'b0;
				if (b != 8'hFF) mac_cand[1] = 1'b0;
				if (b != ALL_NODES_MAC[fr_idx - ndpc_pkg::POS_MAC_SRC_FIRST]) mac_cand[2] = 1'b0;
			end
			if (fr_idx == ndpc_pkg::POS_ETYPE_HI || fr_idx == ndpc_pkg::POS_ETYPE_LO)
				etype_acc = {etype_acc[7:0], b};
			if (fr_idx == ndpc_pkg::POS_NEXT_HDR) nh_cur = b;
			if (fr_idx == ndpc_pkg::POS_HOP_LIMIT) hop_seen = b;
			if (fr_idx == ndpc_pkg::POS_IP_SRC_FIRST) src_lead = b;
			if (fr_idx >= ndpc_pkg::POS_IP_SRC_FIRST && fr_idx <= ndpc_pkg::POS_IP_SRC_LAST &&
			    b != 8'h00)
				src_all_zero = 1'b0;
			if (walk == ndpc_pkg::PH_WALK && fr_idx == hdr_start) begin
				if (chained_header(nh_cur)) begin
					nh_cur = b;
					walk = ndpc_pkg::PH_LEN;
				end else if (nh_cur == ndpc_pkg::NH_ICMPV6) begin
					icmp_pos = (fr_idx > int'(ndpc_pkg::OFFSET_MAX)) ?
						ndpc_pkg::OFFSET_MAX : fr_idx[10:0];
					icmp_ty = b;
					walk = ndpc_pkg::PH_FOUND;
				end else begin
					walk = ndpc_pkg::PH_STOP;
				end
			end else if (walk == ndpc_pkg::PH_LEN && fr_idx == hdr_start + 1) begin
				nxt = hdr_start + (int'(b) + 1) * 8;
				if (nxt >= FRAME_CAP) begin
					walk = ndpc_pkg::PH_STOP;
				end else begin
					hdr_start = nxt;
					walk = ndpc_pkg::PH_WALK;
				end
			end
			fr_idx++;
		end
		if (fin) begin
			mac = mac_cand;
			// source mac bytes never seen count as zero
			if (fr_idx < ndpc_pkg::POS_MAC_SRC_END) mac &= 3'b001;
			ipv6 = (fr_idx >= ndpc_pkg::POS_ETYPE_END) && (etype_acc == ndpc_pkg::ETYPE_IP6);
			found = ipv6 && (walk == ndpc_pkg::PH_FOUND);
			v.ipv6 = ipv6;
			v.src_spec = ipv6 && !src_all_zero;
			v.icmp = found;
			v.off = found ? icmp_pos : 11'd0;
			v.typ = found ? icmp_ty : 8'h00;
			v.ndp = found && icmp_ty >= ndpc_pkg::NDP_TYPE_LO && icmp_ty <= ndpc_pkg::NDP_TYPE_HI;
			v.mac_bcast = (mac != 3'b000);
			v.src_mcast = ipv6 && (src_lead == ndpc_pkg::ADDR_MCAST);
			v.hop_bad = ipv6 && (hop_seen != ndpc_pkg::HOP_LIMIT_OK);
			expected_verdicts.push_back(v);
			clear_frame_state();
		end
	endtask

	task automatic check_field(input string name, input logic [10:0] got, input logic [10:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch, got %0h expected %0h", $time, name, got, want);
			err_cnt++;
		end
	endtask

	// builds an ethernet + ipv6 frame with an optional extension chain in frame_buf
	task automatic make_frame(input mac_kind_t mk, input logic [15:0] et, input logic [7:0] hop,
			input src_kind_t sk, input int n_ext, input int ext_len, input logic [7:0] last_nh,
			input logic [7:0] icmp_t, input int tail);
		int         rot;
		int         p;
		int         len;
		logic [7:0] b;
		frame_buf.delete();
		rot = $urandom_range(3);
		for (int i = 0; i < 6; i++) frame_buf.push_back(8'($urandom_range(255)));
		for (int i = 0; i < 6; i++) begin
			case (mk) inside
				MAC_ZERO:  b = 8'h00;
				MAC_ONES:  b = 8'hFF;
				MAC_MCAST, MAC_NEAR: b = ALL_NODES_MAC[i];
				default:   b = 8'($urandom_range(255));
			endcase
			frame_buf.push_back(b);
		end
		if (mk == MAC_NEAR) begin
			p = $urandom_range(5);
			frame_buf[ndpc_pkg::POS_MAC_SRC_FIRST + p] ^= 8'($urandom_range(1, 255));
		end
		frame_buf.push_back(et[15:8]);
		frame_buf.push_back(et[7:0]);
		frame_buf.push_back(8'h60);
		for (int i = 0; i < 5; i++) frame_buf.push_back(8'($urandom_range(255)));
		frame_buf.push_back((n_ext > 0) ? CHAIN_TYPES[rot] : last_nh);
		frame_buf.push_back(hop);
		p = $urandom_range(15);
		for (int i = 0; i < 16; i++) begin
			case (sk)
				SRC_ZERO:    b = 8'h00;
				SRC_MCAST:   b = (i == 0) ? ndpc_pkg::ADDR_MCAST : 8'($urandom_range(255));
				SRC_ONE_SET: b = (i == p) ? 8'($urandom_range(1, 255)) : 8'h00;
				default:     b = 8'($urandom_range(255));
			endcase
			frame_buf.push_back(b);
		end
		for (int i = 0; i < 16; i++) frame_buf.push_back(8'($urandom_range(255)));
		for (int k = 0; k < n_ext; k++) begin
			len = (ext_len < 0) ? $urandom_range(3) : ext_len;
			frame_buf.push_back((k == n_ext - 1) ? last_nh : CHAIN_TYPES[(k + 1 + rot) % 4]);
			frame_buf.push_back(8'(len));
			for (int i = 0; i < (len + 1) * 8 - 2; i++)
				frame_buf.push_back(8'($urandom_range(255)));
		end
		icmp_slot = frame_buf.size();
		frame_buf.push_back(icmp_t);
		for (int i = 0; i < tail; i++) frame_buf.push_back(8'($urandom_range(255)));
	endtask

	// queues the first len words of frame_buf, padding with random data past its end
	task automatic send_frame(input int len);
		frame_word_t w;
		for (int i = 0; i < len; i++) begin
			w.data = (i < frame_buf.size()) ? frame_buf[i] : 8'($urandom_range(255));
			w.fin = (i == len - 1);
			pending_words.push_back(w);
		end
		n_words += (len < FRAME_CAP) ? len : FRAME_CAP;
	endtask

	task automatic rand_frame();
		mac_kind_t   mk;
		src_kind_t   sk;
		logic [15:0] et;
		logic [7:0]  hop;
		logic [7:0]  nh;
		logic [7:0]  ty;
		int          n_ext;
		int          r;
		int          len;
		r = $urandom_range(99);
		if (r < 12) begin
			// noise, sometimes with a plausible ethertype
			frame_buf.delete();
			len = $urandom_range(1, 80);
			for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(255)));
			if (len > ndpc_pkg::POS_ETYPE_LO && $urandom_range(1)) begin
				frame_buf[ndpc_pkg::POS_ETYPE_HI] = ndpc_pkg::ETYPE_IP6[15:8];
				frame_buf[ndpc_pkg::POS_ETYPE_LO] = ndpc_pkg::ETYPE_IP6[7:0];
			end
			send_frame(len);
			return;
		end
		r = $urandom_range(99);
		mk = (r < 70) ? MAC_RAND : mac_kind_t'($urandom_range(1, 4));
		r = $urandom_range(99);
		case ($urandom_range(3))
			0: et = 16'h0800;
			1: et = 16'h86DC;
			2: et = 16'h87DD;
			default: et = 16'($urandom_range(16'hFFFF));
		endcase
		if (r < 85) et = ndpc_pkg::ETYPE_IP6;
		hop = ($urandom_range(99) < 80) ? ndpc_pkg::HOP_LIMIT_OK : 8'($urandom_range(254));
		r = $urandom_range(99);
		sk = (r < 55) ? SRC_RAND : src_kind_t'($urandom_range(1, 3));
		n_ext = ($urandom_range(99) < 40) ? 0 : $urandom_range(1, 3);
		case ($urandom_range(3))
			0: nh = 8'd6;
			1: nh = 8'd17;
			2: nh = 8'd59;
			default: nh = 8'($urandom_range(255));
		endcase
		if ($urandom_range(99) < 85) nh = ndpc_pkg::NH_ICMPV6;
		ty = ($urandom_range(1)) ?
			8'($urandom_range(ndpc_pkg::NDP_TYPE_LO, ndpc_pkg::NDP_TYPE_HI)) :
			8'($urandom_range(255));
		make_frame(mk, et, hop, sk, n_ext, -1, nh, ty, $urandom_range(4, 24));
		r = $urandom_range(99);
		if (r < 75) len = frame_buf.size();
		else if (r < 84) len = $urandom_range(1, frame_buf.size());
		else if (r < 92) len = icmp_slot;
		else len = icmp_slot + 1;
		send_frame(len);
	endtask

	task automatic directed_frames();
		logic [7:0] types [6] = '{8'd128, 8'd129, 8'd132, 8'd133, 8'd137, 8'd138};
		mac_kind_t  macs [6] = '{MAC_ONES, MAC_NEAR, MAC_MCAST, MAC_ZERO, MAC_RAND, MAC_NEAR};
		make_frame(MAC_ZERO, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, 0, -1,
			ndpc_pkg::NH_ICMPV6, 8'd135, 8);
		send_frame(1);
		send_frame(9);
		make_frame(MAC_MCAST, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, 0, -1,
			ndpc_pkg::NH_ICMPV6, 8'd135, 8);
		send_frame(9);
		make_frame(MAC_ONES, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, 0, -1,
			ndpc_pkg::NH_ICMPV6, 8'd135, 8);
		send_frame(12);
		send_frame(13);
		send_frame(14);
		for (int i = 0; i < 6; i++) begin
			make_frame(macs[i], ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, i % 3, 0,
				ndpc_pkg::NH_ICMPV6, types[i], 2);
			send_frame(frame_buf.size());
		end
		// every extension type in one chain
		make_frame(MAC_RAND, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, 4, 0,
			ndpc_pkg::NH_ICMPV6, 8'd136, 2);
		send_frame(frame_buf.size());
		// unknown next header ends the walk
		make_frame(MAC_RAND, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, 1, 0, 8'd6,
			8'd135, 2);
		send_frame(frame_buf.size());
		// icmp header just outside and just inside the frame
		make_frame(MAC_RAND, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, 1, 1,
			ndpc_pkg::NH_ICMPV6, 8'd134, 2);
		send_frame(icmp_slot);
		send_frame(icmp_slot + 1);
		make_frame(MAC_RAND, ndpc_pkg::ETYPE_IP6, 8'd0, SRC_ZERO, 0, -1, ndpc_pkg::NH_ICMPV6,
			8'd133, 2);
		send_frame(frame_buf.size());
		make_frame(MAC_RAND, ndpc_pkg::ETYPE_IP6, 8'd254, SRC_MCAST, 0, -1, ndpc_pkg::NH_ICMPV6,
			8'd136, 2);
		send_frame(frame_buf.size());
		make_frame(MAC_RAND, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_ONE_SET, 0, -1,
			ndpc_pkg::NH_ICMPV6, 8'd137, 2);
		send_frame(frame_buf.size());
		make_frame(MAC_ONES, 16'h0800, 8'd1, SRC_MCAST, 0, -1, ndpc_pkg::NH_ICMPV6, 8'd135, 2);
		send_frame(frame_buf.size());
		// long header puts the icmp header deep in the frame
		make_frame(MAC_RAND, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, 1, 10,
			ndpc_pkg::NH_ICMPV6, 8'd134, 2);
		send_frame(frame_buf.size());
		// chain that steps past the byte limit
		make_frame(MAC_RAND, ndpc_pkg::ETYPE_IP6, ndpc_pkg::HOP_LIMIT_OK, SRC_RAND, 1, 255,
			ndpc_pkg::NH_ICMPV6, 8'd135, 2);
		send_frame(60);
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || data_valid || expected_verdicts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int start;
		int n_frames;
		snd_idle_pct = 17;
		rcv_idle_pct = 64;
		n_words = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 64 : 0;
			rcv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 17 : 0;
			if (ph == 0) directed_frames();
			start = n_words;
			n_frames = 0;
			while (n_words - start < PHASE_WORDS || n_frames < MIN_FRAMES) begin
				rand_frame();
				n_frames++;
			end
			wait_drained();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// word driver
	always @(posedge clk or negedge arst_n) begin : drive_words
		frame_word_t w;
		if (!arst_n) begin
			data_valid <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
		end else if (!data_valid || data_ready) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				w = pending_words.pop_front();
				data_valid <= 1'b1;
				data_byte <= w.data;
				last_byte <= w.fin;
			end else begin
				data_valid <= 1'b0;
			end
		end
	end

	// verdict receiver, with one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			verdict_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_verdicts >= 6) begin
			verdict_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			verdict_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) clear_frame_state();
		else if (data_valid && data_ready) classify_byte(data_byte, last_byte);
	end

	// verdict checker and stall watchdog
	always @(posedge clk or negedge arst_n) begin : check_verdicts
		ndp_verdict_t e;
		if (!arst_n) begin
			n_verdicts <= 0;
			stall_cnt = 0;
		end else begin
			if (verdict_valid && verdict_ready) begin
				n_verdicts <= n_verdicts + 1;
				if (expected_verdicts.size() == 0) begin
					check_field("unexpected verdict", 11'd1, 11'd0);
				end else begin
					e = expected_verdicts.pop_front();
					check_field("is_ipv6", 11'(is_ipv6), 11'(e.ipv6));
					check_field("src_specified", 11'(src_specified), 11'(e.src_spec));
					check_field("is_icmpv6", 11'(is_icmpv6), 11'(e.icmp));
					check_field("icmp_offset", icmp_offset, e.off);
					check_field("icmp_type", 11'(icmp_type), 11'(e.typ));
					check_field("is_ndp", 11'(is_ndp), 11'(e.ndp));
					check_field("eth_src_broadcast", 11'(eth_src_broadcast), 11'(e.mac_bcast));
					check_field("ip_src_multicast", 11'(ip_src_multicast), 11'(e.src_mcast));
					check_field("hop_limit_bad", 11'(hop_limit_bad), 11'(e.hop_bad));
				end
			end
			if ((data_valid && data_ready) || (verdict_valid && verdict_ready)) stall_cnt = 0;
			else stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
